>>> hdl/dbra_pkg.sv
`timescale 1ns / 1ps

package dbra_pkg;

	localparam int CFG_W      = 13;
	localparam int CFG_IDX_W  = 2;
	localparam int LOG_W      = 5;
	localparam int CB_W       = 4;
	localparam int MODE_W     = 3;
	localparam int DIR_W      = 2;
	localparam int TILE_IDX_W = 12;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_FRAME_WIDTH  = 2'd0,
		REG_FRAME_HEIGHT = 2'd1,
		REG_TILE_LOG2    = 2'd2,
		REG_ORIENT_MODE  = 2'd3
	} cfg_reg_t;

	typedef logic [DIR_W-1:0] tile_dir_t;

	localparam tile_dir_t DIR_RIGHT = 2'd1;
	localparam tile_dir_t DIR_LEFT  = 2'd3;

	localparam logic [MODE_W-1:0] MODE_MAP = 3'd4;

	localparam logic [CFG_W-1:0]  RST_FRAME_WIDTH  = 13'd640;
	localparam logic [CFG_W-1:0]  RST_FRAME_HEIGHT = 13'd480;
	localparam logic [CB_W-1:0]   RST_TILE_LOG2    = 4'd4;
	localparam logic [MODE_W-1:0] RST_ORIENT_MODE  = 3'd4;

endpackage

>>> hdl/dbra_ram.sv
`timescale 1ns / 1ps

module dbra_ram #(
	parameter int WIDTH = 2,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[addr];
		end
	end

	assign rdata = rdata_q;

endmodule

>>> hdl/dice_block_rotate_address_top.sv
`timescale 1ns / 1ps

// channel  handshake              payload
// req      req_valid / req_ready  func, src_x, src_y, tile_index, tile_dir
// rsp      rsp_valid / rsp_ready  dest_x, dest_y, in_tile, beyond_map
// cfg      cfg_we                 cfg_index, cfg_data
//
// one transaction per cycle sustained while rsp_ready is high; a request passes the input register,
// tile split, tile index multiply with map read, and rotate into the output register.
// the single map ram port is shared by read and write, one access per cycle.
// after reset the map is cleared one entry a cycle, with req_ready low until every entry is cleared.
// each stage holds only while the stage after it is full and stalled, so bubbles close up.

module dice_block_rotate_address_top import dbra_pkg::*; #(
	parameter int COORD_BITS = 12,
	parameter int MAP_DEPTH  = 4096
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_W-1:0]      cfg_data,
	input  logic                  req_valid,
	output logic                  req_ready,
	input  logic                  func,
	input  logic [COORD_BITS-1:0] src_x,
	input  logic [COORD_BITS-1:0] src_y,
	input  logic [TILE_IDX_W-1:0] tile_index,
	input  logic [DIR_W-1:0]      tile_dir,
	output logic                  rsp_valid,
	input  logic                  rsp_ready,
	output logic [COORD_BITS-1:0] dest_x,
	output logic [COORD_BITS-1:0] dest_y,
	output logic                  in_tile,
	output logic                  beyond_map
);

	localparam int CW    = COORD_BITS;
	localparam int DW    = COORD_BITS + 1;
	localparam int EXT_W = (CFG_W > DW) ? CFG_W : DW;
	localparam int AW    = $clog2(MAP_DEPTH);
	localparam int TW    = 2 * COORD_BITS + 1;
	localparam int CMP_W = (TW > 17) ? TW : 17;

	localparam logic [EXT_W-1:0] DIM_TOP    = EXT_W'(1) << CW;
	localparam logic [AW-1:0]    CLR_LAST   = AW'(MAP_DEPTH - 1);
	localparam logic [CMP_W-1:0] DEPTH_CMP  = CMP_W'(MAP_DEPTH);

	// configuration registers
	logic [CFG_W-1:0]  frame_width_q;
	logic [CFG_W-1:0]  frame_height_q;
	logic [CB_W-1:0]   tile_log2_q;
	logic [MODE_W-1:0] orient_mode_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q  <= RST_FRAME_WIDTH;
			frame_height_q <= RST_FRAME_HEIGHT;
			tile_log2_q    <= RST_TILE_LOG2;
			orient_mode_q  <= RST_ORIENT_MODE;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_FRAME_WIDTH:  frame_width_q  <= cfg_data;
				REG_FRAME_HEIGHT: frame_height_q <= cfg_data;
				REG_TILE_LOG2:    tile_log2_q    <= cfg_data[CB_W-1:0];
				REG_ORIENT_MODE:  orient_mode_q  <= cfg_data[MODE_W-1:0];
				default: ;
			endcase
		end
	end

	// frame geometry, recomputed every cycle from the configuration
	logic [EXT_W-1:0] w_ext, h_ext;
	logic [DW-1:0]    w_d, h_d, near_d, size_d, map_w_d, end_x_d, end_y_d;
	logic [LOG_W-1:0] flog_d;
	logic [CB_W-1:0]  cb_d;
	logic [CW-1:0]    mask_d, shift_w_d, shift_h_d;

	always_comb begin
		w_ext = EXT_W'(frame_width_q);
		h_ext = EXT_W'(frame_height_q);
		if (w_ext == '0) w_ext = EXT_W'(1);
		if (w_ext > DIM_TOP) w_ext = DIM_TOP;
		if (h_ext == '0) h_ext = EXT_W'(1);
		if (h_ext > DIM_TOP) h_ext = DIM_TOP;
		w_d    = DW'(w_ext);
		h_d    = DW'(h_ext);
		near_d = (w_d < h_d) ? w_d : h_d;
		flog_d = '0;
		for (int i = 0; i < DW; i++) begin
			if (near_d[i]) flog_d = LOG_W'(i);
		end
		cb_d      = (LOG_W'(tile_log2_q) < flog_d) ? tile_log2_q : CB_W'(flog_d);
		size_d    = DW'(1) << cb_d;
		mask_d    = CW'(size_d - DW'(1));
		map_w_d   = w_d >> cb_d;
		// half of the leftover margin, floor on the left and top
		shift_w_d = CW'((w_d & DW'(mask_d)) >> 1);
		shift_h_d = CW'((h_d & DW'(mask_d)) >> 1);
		end_x_d   = DW'(shift_w_d) + (w_d & ~DW'(mask_d));
		end_y_d   = DW'(shift_h_d) + (h_d & ~DW'(mask_d));
	end

	logic [CB_W-1:0] cb_q;
	logic [CW-1:0]   mask_q, shift_w_q, shift_h_q;
	logic [DW-1:0]   map_w_q, end_x_q, end_y_q;
	logic            mode_map_q;
	tile_dir_t       fixed_dir_q;

	always_ff @(posedge clk) begin
		cb_q        <= cb_d;
		mask_q      <= mask_d;
		shift_w_q   <= shift_w_d;
		shift_h_q   <= shift_h_d;
		map_w_q     <= map_w_d;
		end_x_q     <= end_x_d;
		end_y_q     <= end_y_d;
		mode_map_q  <= (orient_mode_q >= MODE_MAP);
		fixed_dir_q <= orient_mode_q[DIR_W-1:0];
	end

	// map clearing after reset
	logic          clearing_q;
	logic [AW-1:0] clr_addr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q <= 1'b1;
			clr_addr_q <= '0;
		end else if (clearing_q) begin
			clr_addr_q <= clr_addr_q + AW'(1);
			if (clr_addr_q == CLR_LAST) clearing_q <= 1'b0;
		end
	end

	// stage enables
	logic valid_s1, valid_s2, valid_s3, out_valid_q;
	logic en1, en2, en3, en_out;

	assign en_out    = !out_valid_q || rsp_ready;
	assign en3       = !valid_s3 || en_out;
	assign en2       = !valid_s2 || en3;
	assign en1       = !valid_s1 || en2;
	assign req_ready = en1 && !clearing_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			valid_s3    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (en1) valid_s1 <= req_valid && req_ready;
			if (en2) valid_s2 <= valid_s1;
			if (en3) valid_s3 <= valid_s2;
			if (en_out) out_valid_q <= valid_s3;
		end
	end

	// stage 1: input register, tile position
	logic                  func_s1;
	logic [CW-1:0]         sx_s1, sy_s1;
	logic [TILE_IDX_W-1:0] idx_s1;
	tile_dir_t             dir_s1;

	always_ff @(posedge clk) begin
		if (en1) begin
			func_s1 <= func;
			sx_s1   <= src_x;
			sy_s1   <= src_y;
			idx_s1  <= tile_index;
			dir_s1  <= tile_dir;
		end
	end

	logic          inside_c;
	logic [CW-1:0] lx_c, ly_c;

	always_comb begin
		inside_c = (sx_s1 >= shift_w_q) && (DW'(sx_s1) < end_x_q) &&
			(sy_s1 >= shift_h_q) && (DW'(sy_s1) < end_y_q);
		lx_c = sx_s1 - shift_w_q;
		ly_c = sy_s1 - shift_h_q;
	end

	// stage 2: tile index, map access
	logic                  func_s2, inside_s2;
	logic [CW-1:0]         sx_s2, sy_s2, tx_s2, ty_s2, lx_s2, ly_s2;
	logic [TILE_IDX_W-1:0] idx_s2;
	tile_dir_t             dir_s2;

	always_ff @(posedge clk) begin
		if (en2) begin
			func_s2   <= func_s1;
			inside_s2 <= inside_c;
			sx_s2     <= sx_s1;
			sy_s2     <= sy_s1;
			tx_s2     <= lx_c >> cb_q;
			ty_s2     <= ly_c >> cb_q;
			lx_s2     <= lx_c & mask_q;
			ly_s2     <= ly_c & mask_q;
			idx_s2    <= idx_s1;
			dir_s2    <= dir_s1;
		end
	end

	logic [TW-1:0]  tile_c;
	logic           idx_ok_c, beyond_c;
	logic           ram_we;
	logic [AW-1:0]  ram_addr;
	tile_dir_t      ram_wdata, ram_rdata;

	always_comb begin
		tile_c    = TW'(ty_s2) * TW'(map_w_q) + TW'(tx_s2);
		idx_ok_c  = CMP_W'(idx_s2) < DEPTH_CMP;
		beyond_c  = mode_map_q && (CMP_W'(tile_c) >= DEPTH_CMP);
		ram_we    = clearing_q || (valid_s2 && en3 && !func_s2 && idx_ok_c);
		ram_wdata = clearing_q ? '0 : dir_s2;
		if (clearing_q) begin
			ram_addr = clr_addr_q;
		end else if (func_s2) begin
			ram_addr = AW'(tile_c);
		end else begin
			ram_addr = AW'(idx_s2);
		end
	end

	dbra_ram #(
		.WIDTH (DIR_W),
		.DEPTH (MAP_DEPTH)
	) u_map (
		.clk   (clk),
		.we    (ram_we),
		.re    (en3),
		.addr  (ram_addr),
		.wdata (ram_wdata),
		.rdata (ram_rdata)
	);

	// stage 3: rotate within the tile
	logic          func_s3, inside_s3, beyond_s3;
	logic [CW-1:0] sx_s3, sy_s3, tx_s3, ty_s3, lx_s3, ly_s3;

	always_ff @(posedge clk) begin
		if (en3) begin
			func_s3   <= func_s2;
			inside_s3 <= inside_s2;
			beyond_s3 <= beyond_c;
			sx_s3     <= sx_s2;
			sy_s3     <= sy_s2;
			tx_s3     <= tx_s2;
			ty_s3     <= ty_s2;
			lx_s3     <= lx_s2;
			ly_s3     <= ly_s2;
		end
	end

	tile_dir_t     dir_c;
	logic [CW-1:0] ox_c, oy_c;
	logic [CW-1:0] dx_c, dy_c;
	logic          in_tile_c, beyond_out_c;

	always_comb begin
		dir_c = mode_map_q ? ram_rdata : fixed_dir_q;
		case (dir_c)
			DIR_RIGHT: begin
				ox_c = ly_s3;
				oy_c = mask_q - lx_s3;
			end
			DIR_LEFT: begin
				ox_c = mask_q - ly_s3;
				oy_c = lx_s3;
			end
			// up and down both turn half way
			default: begin
				ox_c = mask_q - lx_s3;
				oy_c = mask_q - ly_s3;
			end
		endcase
		if (!func_s3) begin
			dx_c         = '0;
			dy_c         = '0;
			in_tile_c    = 1'b0;
			beyond_out_c = 1'b0;
		end else if (!inside_s3 || beyond_s3) begin
			dx_c         = sx_s3;
			dy_c         = sy_s3;
			in_tile_c    = 1'b0;
			beyond_out_c = inside_s3;
		end else begin
			dx_c         = shift_w_q + (tx_s3 << cb_q) + ox_c;
			dy_c         = shift_h_q + (ty_s3 << cb_q) + oy_c;
			in_tile_c    = 1'b1;
			beyond_out_c = 1'b0;
		end
	end

	// output register
	logic [CW-1:0] dest_x_q, dest_y_q;
	logic          in_tile_q, beyond_q;

	always_ff @(posedge clk) begin
		if (en_out) begin
			dest_x_q  <= dx_c;
			dest_y_q  <= dy_c;
			in_tile_q <= in_tile_c;
			beyond_q  <= beyond_out_c;
		end
	end

	assign rsp_valid  = out_valid_q;
	assign dest_x     = dest_x_q;
	assign dest_y     = dest_y_q;
	assign in_tile    = in_tile_q;
	assign beyond_map = beyond_q;

	a_no_accept_while_clearing: assert property (@(posedge clk) disable iff (!arst_n)
		clearing_q |-> !req_ready)
		else $error("request taken during map clearing");

	a_clear_runs_once: assert property (@(posedge clk) disable iff (!arst_n)
		!clearing_q |=> !clearing_q)
		else $error("map clearing restarted");

	a_beyond_not_in_tile: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && beyond_map) |-> !in_tile)
		else $error("tile flagged beyond map and rotated");

	a_beyond_only_map_mode: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && beyond_map) |-> mode_map_q)
		else $error("beyond map flagged in a fixed orientation mode");

endmodule

>>> verif/dbra_tb_pkg.sv
`timescale 1ns / 1ps

package dbra_tb_pkg;

	import dbra_pkg::*;

	typedef enum logic {
		FUNC_WRITE     = 1'b0,
		FUNC_TRANSLATE = 1'b1
	} req_func_t;

	localparam tile_dir_t DIR_UP   = 2'd0;
	localparam tile_dir_t DIR_DOWN = 2'd2;

	// raw mode code above the map mode, the block treats it as the map mode
	localparam logic [MODE_W-1:0] MODE_RAW_MAX = 3'd7;

endpackage

>>> verif/dbra_checker.sv
`timescale 1ns / 1ps

module dbra_checker import dbra_pkg::*, dbra_tb_pkg::*; #(
	parameter int COORD_BITS = 12,
	parameter int MAP_DEPTH  = 4096
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_W-1:0]      cfg_data,
	input  logic                  req_valid,
	input  logic                  req_ready,
	input  logic                  func,
	input  logic [COORD_BITS-1:0] src_x,
	input  logic [COORD_BITS-1:0] src_y,
	input  logic [TILE_IDX_W-1:0] tile_index,
	input  logic [DIR_W-1:0]      tile_dir,
	input  logic                  rsp_valid,
	input  logic                  rsp_ready,
	input  logic [COORD_BITS-1:0] dest_x,
	input  logic [COORD_BITS-1:0] dest_y,
	input  logic                  in_tile,
	input  logic                  beyond_map,
	output int                    fail_count,
	output int                    pending,
	output int                    checked,
	output int                    rotated,
	output int                    beyond
);

	typedef struct packed {
		logic [COORD_BITS-1:0] x;
		logic [COORD_BITS-1:0] y;
		logic                  turned;
		logic                  past_map;
	} dest_t;

	dest_t             dest_q[$];
	tile_dir_t         dir_map [MAP_DEPTH];
	logic [CFG_W-1:0]  width_reg;
	logic [CFG_W-1:0]  height_reg;
	logic [CB_W-1:0]   log2_reg;
	logic [MODE_W-1:0] mode_reg;

	function automatic dest_t map_coord(input logic [COORD_BITS-1:0] sx,
			input logic [COORD_BITS-1:0] sy);
		int unsigned lim, w, h, shortest, lg, side, cols, rows, off_x, off_y;
		int unsigned lx, ly, tx, ty, ox, oy, tile;
		logic [MODE_W-1:0] mode;
		tile_dir_t dir;
		dest_t res;
		lim = 1 << COORD_BITS;
		w = (width_reg == 0) ? 1 : ((width_reg > lim) ? lim : width_reg);
		h = (height_reg == 0) ? 1 : ((height_reg > lim) ? lim : height_reg);
		shortest = (w < h) ? w : h;
		lg = 0;
		while ((2 << lg) <= shortest)
			lg++;
		if (log2_reg < lg)
			lg = log2_reg;
		mode = (mode_reg > MODE_MAP) ? MODE_MAP : mode_reg;
		side = 1 << lg;
		cols = w >> lg;
		rows = h >> lg;
		// grid is centred, odd leftover goes to the right and bottom
		off_x = (w - side * cols) >> 1;
		off_y = (h - side * rows) >> 1;
		res = '0;
		res.x = sx;
		res.y = sy;
		if (sx < off_x || sx >= off_x + side * cols || sy < off_y || sy >= off_y + side * rows)
			return res;
		lx = sx - off_x;
		ly = sy - off_y;
		tx = lx >> lg;
		ty = ly >> lg;
		lx &= side - 1;
		ly &= side - 1;
		if (mode == MODE_MAP) begin
			tile = ty * cols + tx;
			if (tile >= MAP_DEPTH) begin
				res.past_map = 1'b1;
				return res;
			end
			dir = dir_map[tile];
		end else begin
			dir = mode[DIR_W-1:0];
		end
		case (dir)
			DIR_RIGHT: begin
				ox = ly;
				oy = side - 1 - lx;
			end
			DIR_LEFT: begin
				ox = side - 1 - ly;
				oy = lx;
			end
			// up and down are both a half turn
			default: begin
				ox = side - 1 - lx;
				oy = side - 1 - ly;
			end
		endcase
		res.x = COORD_BITS'(off_x + (tx << lg) + ox);
		res.y = COORD_BITS'(off_y + (ty << lg) + oy);
		res.turned = 1'b1;
		return res;
	endfunction

	task automatic report_mismatch(input string what);
		$display("[%0t] dbra_checker: result %0d: %s", $time, checked, what);
		fail_count++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		dest_t want;
		dest_t got;
		if (!arst_n) begin
			dest_q.delete();
			foreach (dir_map[i])
				dir_map[i] = DIR_UP;
			width_reg  = RST_FRAME_WIDTH;
			height_reg = RST_FRAME_HEIGHT;
			log2_reg   = RST_TILE_LOG2;
			mode_reg   = RST_ORIENT_MODE;
			fail_count = 0;
			pending    <= 0;
			checked    <= 0;
			rotated    <= 0;
			beyond     <= 0;
		end else begin
			if (cfg_we) begin
				case (cfg_reg_t'(cfg_index))
					REG_FRAME_WIDTH:  width_reg  = cfg_data;
					REG_FRAME_HEIGHT: height_reg = cfg_data;
					REG_TILE_LOG2:    log2_reg   = cfg_data[CB_W-1:0];
					REG_ORIENT_MODE:  mode_reg   = cfg_data[MODE_W-1:0];
					default: ;
				endcase
			end
			// retire the response before queueing a new request
			if (rsp_valid && rsp_ready) begin
				got.x = dest_x;
				got.y = dest_y;
				got.turned = in_tile;
				got.past_map = beyond_map;
				if (dest_q.size() == 0) begin
					report_mismatch("response with no request outstanding");
				end else begin
					want = dest_q.pop_front();
					if (got.x !== want.x)
						report_mismatch($sformatf("dest_x %0d, expected %0d", got.x, want.x));
					if (got.y !== want.y)
						report_mismatch($sformatf("dest_y %0d, expected %0d", got.y, want.y));
					if (got.turned !== want.turned)
						report_mismatch($sformatf("in_tile %b, expected %b",
							got.turned, want.turned));
					if (got.past_map !== want.past_map)
						report_mismatch($sformatf("beyond_map %b, expected %b",
							got.past_map, want.past_map));
					rotated <= rotated + want.turned;
					beyond  <= beyond + want.past_map;
				end
				checked <= checked + 1;
			end
			if (req_valid && req_ready) begin
				if (func == FUNC_WRITE) begin
					if (tile_index < MAP_DEPTH)
						dir_map[tile_index] = tile_dir;
					dest_q.push_back('0);
				end else begin
					dest_q.push_back(map_coord(src_x, src_y));
				end
			end
			pending <= dest_q.size();
		end
	end

endmodule

>>> verif/tb_dice_block_rotate_address_top.sv
`timescale 1ns / 1ps

module tb_dice_block_rotate_address_top;

	import dbra_pkg::*;
	import dbra_tb_pkg::*;

	localparam int COORD_BITS  = 12;
	localparam int MAP_DEPTH   = 4096;
	localparam int CYCLE_LIMIT = 400000;
	localparam int PHASE_ITEMS = 50;

	logic                  clk        = 1'b0;
	logic                  arst_n     = 1'b0;
	logic                  cfg_we     = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index  = '0;
	logic [CFG_W-1:0]      cfg_data   = '0;
	logic                  req_valid  = 1'b0;
	logic                  func       = 1'b0;
	logic [COORD_BITS-1:0] src_x      = '0;
	logic [COORD_BITS-1:0] src_y      = '0;
	logic [TILE_IDX_W-1:0] tile_index = '0;
	logic [DIR_W-1:0]      tile_dir   = '0;
	logic                  rsp_ready  = 1'b0;
	logic                  req_ready;
	logic                  rsp_valid;
	logic [COORD_BITS-1:0] dest_x;
	logic [COORD_BITS-1:0] dest_y;
	logic                  in_tile;
	logic                  beyond_map;

	int fail_count;
	int pending;
	int checked;
	int rotated;
	int beyond;

	int send_idle_pct = 21;
	int rcv_idle_pct  = 74;
	int sent          = 0;
	int settings_run  = 0;
	int cycles        = 0;
	int frame_w       = RST_FRAME_WIDTH;
	int frame_h       = RST_FRAME_HEIGHT;
	int tile_lg       = RST_TILE_LOG2;

	always #10 clk = ~clk;

	dice_block_rotate_address_top #(
		.COORD_BITS (COORD_BITS),
		.MAP_DEPTH  (MAP_DEPTH)
	) i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.req_valid  (req_valid),
		.req_ready  (req_ready),
		.func       (func),
		.src_x      (src_x),
		.src_y      (src_y),
		.tile_index (tile_index),
		.tile_dir   (tile_dir),
		.rsp_valid  (rsp_valid),
		.rsp_ready  (rsp_ready),
		.dest_x     (dest_x),
		.dest_y     (dest_y),
		.in_tile    (in_tile),
		.beyond_map (beyond_map)
	);

	dbra_checker #(
		.COORD_BITS (COORD_BITS),
		.MAP_DEPTH  (MAP_DEPTH)
	) i_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.req_valid  (req_valid),
		.req_ready  (req_ready),
		.func       (func),
		.src_x      (src_x),
		.src_y      (src_y),
		.tile_index (tile_index),
		.tile_dir   (tile_dir),
		.rsp_valid  (rsp_valid),
		.rsp_ready  (rsp_ready),
		.dest_x     (dest_x),
		.dest_y     (dest_y),
		.in_tile    (in_tile),
		.beyond_map (beyond_map),
		.fail_count (fail_count),
		.pending    (pending),
		.checked    (checked),
		.rotated    (rotated),
		.beyond     (beyond)
	);

	always @(posedge clk) begin
		rsp_ready <= ($urandom_range(99) >= rcv_idle_pct);
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycles, pending);
			$display("tb_dice_block_rotate_address_top: FAIL");
			$finish;
		end
	end

	// valid stays up between back-to-back transactions, drops only for a gap
	task automatic send_item(input req_func_t f, input logic [COORD_BITS-1:0] x,
			input logic [COORD_BITS-1:0] y, input logic [TILE_IDX_W-1:0] idx,
			input tile_dir_t d);
		if ($urandom_range(99) < send_idle_pct) begin
			req_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
		end
		req_valid  <= 1'b1;
		func       <= f;
		src_x      <= x;
		src_y      <= y;
		tile_index <= idx;
		tile_dir   <= d;
		@(posedge clk);
		while (!req_ready)
			@(posedge clk);
		sent++;
	endtask

	task automatic drain();
		req_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
	endtask

	task automatic program_cfg(input int w, input int h, input int lg, input int mode);
		cfg_we    <= 1'b1;
		cfg_index <= REG_FRAME_WIDTH;
		cfg_data  <= CFG_W'(w);
		@(posedge clk);
		cfg_index <= REG_FRAME_HEIGHT;
		cfg_data  <= CFG_W'(h);
		@(posedge clk);
		cfg_index <= REG_TILE_LOG2;
		cfg_data  <= CFG_W'(lg);
		@(posedge clk);
		cfg_index <= REG_ORIENT_MODE;
		cfg_data  <= CFG_W'(mode);
		@(posedge clk);
		cfg_we <= 1'b0;
		frame_w = w;
		frame_h = h;
		tile_lg = lg;
		settings_run++;
	endtask

	// mostly map writes to live tiles and translates inside the frame
	task automatic run_random(input int n);
		int unsigned w, h, shortest, lg, tiles, span, pick;
		w = (frame_w < 1) ? 1 : ((frame_w > MAP_DEPTH) ? MAP_DEPTH : frame_w);
		h = (frame_h < 1) ? 1 : ((frame_h > MAP_DEPTH) ? MAP_DEPTH : frame_h);
		shortest = (w < h) ? w : h;
		lg = 0;
		while ((2 << lg) <= shortest)
			lg++;
		if (tile_lg < lg)
			lg = tile_lg;
		tiles = (w >> lg) * (h >> lg);
		span = (tiles > MAP_DEPTH) ? MAP_DEPTH : tiles;
		repeat (n) begin
			pick = $urandom_range(99);
			if (pick < 30)
				send_item(FUNC_WRITE, COORD_BITS'($urandom), COORD_BITS'($urandom),
					(pick < 24) ? TILE_IDX_W'($urandom_range(span - 1)) :
					TILE_IDX_W'($urandom), DIR_W'($urandom));
			else if (pick < 88)
				send_item(FUNC_TRANSLATE, COORD_BITS'($urandom_range(w - 1)),
					COORD_BITS'($urandom_range(h - 1)), TILE_IDX_W'($urandom),
					DIR_W'($urandom));
			else
				send_item(FUNC_TRANSLATE, COORD_BITS'($urandom), COORD_BITS'($urandom),
					TILE_IDX_W'($urandom), DIR_W'($urandom));
		end
	endtask

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// reset settings: 640x480, 16 pixel tiles, per-tile map
		send_item(FUNC_WRITE, 0, 0, 0, DIR_UP);
		send_item(FUNC_WRITE, 0, 0, 1, DIR_RIGHT);
		send_item(FUNC_WRITE, 0, 0, 2, DIR_DOWN);
		send_item(FUNC_WRITE, 0, 0, 3, DIR_LEFT);
		send_item(FUNC_TRANSLATE, 0, 0, 0, DIR_UP);
		send_item(FUNC_TRANSLATE, 15, 15, 0, DIR_UP);
		send_item(FUNC_TRANSLATE, 17, 2, 0, DIR_UP);
		send_item(FUNC_TRANSLATE, 33, 14, 0, DIR_UP);
		send_item(FUNC_TRANSLATE, 50, 9, 0, DIR_UP);
		send_item(FUNC_TRANSLATE, 639, 479, 0, DIR_UP);
		send_item(FUNC_WRITE, 0, 0, 1199, DIR_RIGHT);
		send_item(FUNC_TRANSLATE, 639, 479, 0, DIR_UP);
		send_item(FUNC_WRITE, 4095, 4095, 4095, DIR_LEFT);
		send_item(FUNC_TRANSLATE, 640, 0, 4095, DIR_LEFT);
		send_item(FUNC_TRANSLATE, 4095, 4095, 4095, DIR_LEFT);

		// centred grid with a margin on every side
		drain();
		program_cfg(100, 70, 5, MODE_MAP);
		send_item(FUNC_TRANSLATE, 0, 0, 0, DIR_UP);
		send_item(FUNC_TRANSLATE, 2, 3, 0, DIR_UP);
		send_item(FUNC_TRANSLATE, 97, 66, 0, DIR_UP);
		send_item(FUNC_TRANSLATE, 98, 67, 0, DIR_UP);

		// one pixel tiles over the largest frame, most of them past the map
		drain();
		program_cfg(4096, 4096, 0, MODE_MAP);
		send_item(FUNC_TRANSLATE, 0, 0, 0, DIR_UP);
		send_item(FUNC_TRANSLATE, 5, 1, 0, DIR_UP);
		send_item(FUNC_TRANSLATE, 4095, 0, 0, DIR_UP);

		// zero width, oversized height, tile size and mode above range
		drain();
		program_cfg(0, 8191, 15, MODE_RAW_MAX);
		send_item(FUNC_TRANSLATE, 0, 7, 0, DIR_UP);

		for (int d = 0; d < 4; d++) begin
			drain();
			program_cfg(100, 70, 5, d);
			send_item(FUNC_TRANSLATE, 10, 20, 0, DIR_UP);
		end

		for (int ph = 0; ph < 11; ph++) begin
			if (ph == 4) begin
				send_idle_pct = 74;
				rcv_idle_pct <= 21;
			end
			if (ph == 8) begin
				send_idle_pct = 0;
				rcv_idle_pct <= 0;
			end
			drain();
			case (ph)
				0: program_cfg(RST_FRAME_WIDTH, RST_FRAME_HEIGHT, RST_TILE_LOG2, MODE_MAP);
				1: program_cfg(4096, 4096, 0, MODE_MAP);
				2: program_cfg(4096, 72, 3, MODE_MAP);
				3: program_cfg(1, 1, 15, DIR_RIGHT);
				4: program_cfg(4096, 4096, 12, MODE_MAP);
				5: program_cfg(0, 8191, 2, MODE_RAW_MAX);
				6: program_cfg(4096, 64, 3, MODE_MAP);
				default: program_cfg($urandom_range(1, 4096), $urandom_range(1, 4096),
					$urandom_range(0, 12), $urandom_range(0, 4));
			endcase
			run_random(PHASE_ITEMS);
		end

		drain();
		repeat (10) @(posedge clk);
		$display("sent %0d requests under %0d register settings", sent, settings_run);
		$display("checked %0d results, %0d inside turned tiles, %0d past the map",
			checked, rotated, beyond);
		if (fail_count == 0)
			$display("tb_dice_block_rotate_address_top: PASS");
		else
			$display("tb_dice_block_rotate_address_top: FAIL");
		$finish;
	end

endmodule

>>> files.f
hdl/dbra_pkg.sv
hdl/dbra_ram.sv
hdl/dice_block_rotate_address_top.sv
verif/dbra_tb_pkg.sv
verif/dbra_checker.sv
verif/tb_dice_block_rotate_address_top.sv
